// ===== design/kdet_pkg.sv =====
// Package for the key press event detector: codes, register map and reset values.
package kdet_pkg;

  localparam int CntW  = 16;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [1:0]      code_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_DEBOUNCE = 4'b0010,
    ST_PRESSED  = 4'b0100,
    ST_LONG     = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_SHORT        = 3'd2,
    EV_LONG         = 3'd3,
    EV_REPEAT       = 3'd4,
    EV_LONG_RELEASE = 3'd5
  } event_t;

  localparam code_t KEY_NONE  = 2'd0;
  localparam code_t KEY_ONE   = 2'd1;
  localparam code_t KEY_TWO   = 2'd2;
  localparam code_t BOTH_KEYS = 2'd3;

  localparam logic [2:0] REG_SCAN_PERIOD   = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE_TIME = 3'd1;
  localparam logic [2:0] REG_LONG_TIME     = 3'd2;
  localparam logic [2:0] REG_REPEAT_TIME   = 3'd3;
  localparam logic [2:0] REG_REPEAT_EN     = 3'd4;

  localparam cnt_t RST_SCAN_PERIOD   = 16'd10;
  localparam cnt_t RST_DEBOUNCE_TIME = 16'd20;
  localparam cnt_t RST_LONG_TIME     = 16'd1000;
  localparam cnt_t RST_REPEAT_TIME   = 16'd200;

endpackage

// ===== design/key_press_event_detector_top.sv =====
// Key press event detector: key sampling, debounce state machine and event output.
//
// Usage: each input word is one time tick with the two active-low key pins
// (key_one_pin, key_two_pin), offered with in_valid and held by in_stall.
// Every accepted tick yields exactly one output word (event_kind, key_code)
// on out_valid / out_stall; event_kind 0 means no event on that tick.
// Keys are sampled once every scan_period ticks; a code stable for
// debounce_time ticks reports a press, release before long_press_time
// reports a short press, otherwise a long press, then hold repeats every
// repeat_time ticks (reported when repeat_report_enable is set) and a long
// release. out_valid rises in the cycle after acceptance; one tick is taken
// every cycle unless out_stall holds the single output register full.
// When the receiver stalls, the output word holds and in_stall rises while
// the output register is full and not being taken.
// Reset (rst, synchronous) restores the register defaults, returns the
// state machine to idle with zero countdowns and empties the output.
// Registers sit on an APB port at byte addresses 0,4,8,12,16; pready is always
// high; the user must make writes only while no tick is in flight (unchecked).
module key_press_event_detector_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     key_one_pin,
  input  logic                     key_two_pin,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic [2:0]               event_kind,
  output logic [1:0]               key_code,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [kdet_pkg::AddrW-1:0] paddr,
  input  logic [kdet_pkg::DataW-1:0] pwdata,
  output logic [kdet_pkg::DataW-1:0] prdata,
  output logic                     pready
);

  kdet_pkg::cnt_t   scan_period;
  kdet_pkg::cnt_t   debounce_time;
  kdet_pkg::cnt_t   long_press_time;
  kdet_pkg::cnt_t   repeat_time;
  logic             repeat_report_enable;

  kdet_pkg::state_t state, state_next;
  kdet_pkg::code_t  held_key_code, held_key_code_next;
  kdet_pkg::cnt_t   scan_cnt, scan_cnt_next;
  kdet_pkg::cnt_t   wait_cnt, wait_cnt_next;
  kdet_pkg::event_t ev;

  kdet_pkg::cnt_t   scan_dec, wait_dec;
  kdet_pkg::code_t  code;
  logic             same, due, accept, wr_en;
  logic [2:0]       reg_idx;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period          <= kdet_pkg::RST_SCAN_PERIOD;
      debounce_time        <= kdet_pkg::RST_DEBOUNCE_TIME;
      long_press_time      <= kdet_pkg::RST_LONG_TIME;
      repeat_time          <= kdet_pkg::RST_REPEAT_TIME;
      repeat_report_enable <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        kdet_pkg::REG_SCAN_PERIOD:   scan_period          <= pwdata[15:0];
        kdet_pkg::REG_DEBOUNCE_TIME: debounce_time        <= pwdata[15:0];
        kdet_pkg::REG_LONG_TIME:     long_press_time      <= pwdata[15:0];
        kdet_pkg::REG_REPEAT_TIME:   repeat_time          <= pwdata[15:0];
        kdet_pkg::REG_REPEAT_EN:     repeat_report_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kdet_pkg::REG_SCAN_PERIOD:   prdata = {16'd0, scan_period};
      kdet_pkg::REG_DEBOUNCE_TIME: prdata = {16'd0, debounce_time};
      kdet_pkg::REG_LONG_TIME:     prdata = {16'd0, long_press_time};
      kdet_pkg::REG_REPEAT_TIME:   prdata = {16'd0, repeat_time};
      kdet_pkg::REG_REPEAT_EN:     prdata = {31'd0, repeat_report_enable};
      default:                     prdata = '0;
    endcase
  end

  // handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // tick processing
  always_comb begin
    scan_dec = (scan_cnt != '0) ? scan_cnt - 16'd1 : '0;
    wait_dec = (wait_cnt != '0) ? wait_cnt - 16'd1 : '0;

    if (!key_one_pin && !key_two_pin) code = kdet_pkg::BOTH_KEYS;
    else if (!key_two_pin)            code = kdet_pkg::KEY_TWO;
    else if (!key_one_pin)            code = kdet_pkg::KEY_ONE;
    else                              code = kdet_pkg::KEY_NONE;

    same = (code == held_key_code);
    due  = (wait_dec == '0);

    state_next         = state;
    held_key_code_next = held_key_code;
    scan_cnt_next      = scan_dec;
    wait_cnt_next      = wait_dec;
    ev                 = kdet_pkg::EV_NONE;

    if (scan_dec == '0) begin
      scan_cnt_next = scan_period;
      case (state)
        kdet_pkg::ST_IDLE: begin
          if (code != kdet_pkg::KEY_NONE) begin
            held_key_code_next = code;
            wait_cnt_next      = debounce_time;
            state_next         = kdet_pkg::ST_DEBOUNCE;
          end
        end
        kdet_pkg::ST_DEBOUNCE: begin
          if (!same) begin
            state_next = kdet_pkg::ST_IDLE;
          end else if (due) begin
            wait_cnt_next = long_press_time;
            state_next    = kdet_pkg::ST_PRESSED;
            ev            = kdet_pkg::EV_PRESS;
          end
        end
        kdet_pkg::ST_PRESSED: begin
          if (!same) begin
            state_next = kdet_pkg::ST_IDLE;
            ev         = kdet_pkg::EV_SHORT;
          end else if (due) begin
            wait_cnt_next = repeat_time;
            state_next    = kdet_pkg::ST_LONG;
            ev            = kdet_pkg::EV_LONG;
          end
        end
        default: begin
          if (!same) begin
            state_next = kdet_pkg::ST_IDLE;
            ev         = kdet_pkg::EV_LONG_RELEASE;
          end else if (due) begin
            wait_cnt_next = repeat_time;
            if (repeat_report_enable) ev = kdet_pkg::EV_REPEAT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= kdet_pkg::ST_IDLE;
      held_key_code <= kdet_pkg::KEY_NONE;
      scan_cnt      <= '0;
      wait_cnt      <= '0;
    end else if (accept) begin
      state         <= state_next;
      held_key_code <= held_key_code_next;
      scan_cnt      <= scan_cnt_next;
      wait_cnt      <= wait_cnt_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_kind <= ev;
      key_code   <= (ev == kdet_pkg::EV_NONE) ? kdet_pkg::KEY_NONE : held_key_code;
    end
  end

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no output word");

  a_none_no_key: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == kdet_pkg::EV_NONE) |-> key_code == kdet_pkg::KEY_NONE)
    else $error("key code set on empty event");

  a_held_code: assert property (@(posedge clk) disable iff (rst)
    (state != kdet_pkg::ST_IDLE) |-> held_key_code != kdet_pkg::KEY_NONE)
    else $error("tracking state without a key code");

  a_press_from_debounce: assert property (@(posedge clk) disable iff (rst)
    (accept && ev == kdet_pkg::EV_PRESS) |=> state == kdet_pkg::ST_PRESSED)
    else $error("press event without entering pressed state");

endmodule

// ===== test/tb.sv =====
// Testbench for the key press event detector: random key ticks checked against a tick predictor.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic one;
    logic two;
  } pins_t;

  typedef struct {
    kdet_pkg::event_t ev;
    kdet_pkg::code_t  key;
  } key_event_t;

  localparam int REG_UNUSED_LO = 5;
  localparam int REG_UNUSED_HI = 7;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       key_one_pin = 1'b1;
  logic                       key_two_pin = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [2:0]                 event_kind;
  logic [1:0]                 key_code;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [kdet_pkg::AddrW-1:0] paddr = '0;
  logic [kdet_pkg::DataW-1:0] pwdata = '0;
  logic [kdet_pkg::DataW-1:0] prdata;
  logic                       pready;

  key_press_event_detector_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .key_one_pin(key_one_pin),
    .key_two_pin(key_two_pin),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .event_kind (event_kind),
    .key_code   (key_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predictor copy of registers and state
  kdet_pkg::cnt_t   scan_cfg = kdet_pkg::RST_SCAN_PERIOD;
  kdet_pkg::cnt_t   debounce_cfg = kdet_pkg::RST_DEBOUNCE_TIME;
  kdet_pkg::cnt_t   long_cfg = kdet_pkg::RST_LONG_TIME;
  kdet_pkg::cnt_t   repeat_cfg = kdet_pkg::RST_REPEAT_TIME;
  logic             repeat_en_cfg = 1'b0;
  kdet_pkg::state_t det_state = kdet_pkg::ST_IDLE;
  kdet_pkg::code_t  held_code = kdet_pkg::KEY_NONE;
  kdet_pkg::cnt_t   scan_left = '0;
  kdet_pkg::cnt_t   hold_left = '0;

  pins_t      key_ticks[$];
  key_event_t pending_events[$];
  pins_t      nxt_pins;
  key_event_t want;
  logic       tick_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         n_pushed = 0;
  int         n_results = 0;
  int         n_bad = 0;
  int         n_settings = 0;
  int         ev_seen[6] = '{default: 0};

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic key_event_of_tick(input logic pin_one, input logic pin_two);
    key_event_t      res;
    kdet_pkg::code_t code;
    logic            same;
    logic            due;
    res.ev = kdet_pkg::EV_NONE;
    if (scan_left != '0) scan_left--;
    if (hold_left != '0) hold_left--;
    if (scan_left == '0) begin
      scan_left = scan_cfg;
      code = {~pin_two, ~pin_one};
      same = (code == held_code);
      due = (hold_left == '0);
      case (det_state)
        kdet_pkg::ST_IDLE: begin
          if (code != kdet_pkg::KEY_NONE) begin
            held_code = code;
            hold_left = debounce_cfg;
            det_state = kdet_pkg::ST_DEBOUNCE;
          end
        end
        kdet_pkg::ST_DEBOUNCE: begin
          if (!same) begin
            det_state = kdet_pkg::ST_IDLE;
          end else if (due) begin
            hold_left = long_cfg;
            det_state = kdet_pkg::ST_PRESSED;
            res.ev = kdet_pkg::EV_PRESS;
          end
        end
        kdet_pkg::ST_PRESSED: begin
          if (!same) begin
            det_state = kdet_pkg::ST_IDLE;
            res.ev = kdet_pkg::EV_SHORT;
          end else if (due) begin
            hold_left = repeat_cfg;
            det_state = kdet_pkg::ST_LONG;
            res.ev = kdet_pkg::EV_LONG;
          end
        end
        default: begin
          if (!same) begin
            det_state = kdet_pkg::ST_IDLE;
            res.ev = kdet_pkg::EV_LONG_RELEASE;
          end else if (due) begin
            hold_left = repeat_cfg;
            if (repeat_en_cfg) res.ev = kdet_pkg::EV_REPEAT;
          end
        end
      endcase
    end
    res.key = (res.ev == kdet_pkg::EV_NONE) ? kdet_pkg::KEY_NONE : held_code;
    ev_seen[res.ev]++;
    pending_events.push_back(res);
  endtask

  // monitor: accepted ticks feed the predictor, accepted results are checked
  always @(posedge clk) begin
    tick_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tick_taken = 1'b1;
        key_event_of_tick(key_one_pin, key_two_pin);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_events.size() == 0) begin
          if (n_bad < 10)
            $display("result with no pending tick: kind %0d key %0d", event_kind, key_code);
          n_bad++;
        end else begin
          want = pending_events.pop_front();
          if (event_kind !== want.ev || key_code !== want.key) begin
            if (n_bad < 10)
              $display("mismatch on result %0d: expected kind %0d key %0d, got kind %0d key %0d",
                       n_results, want.ev, want.key, event_kind, key_code);
            n_bad++;
          end
        end
      end
    end
  end

  // driver: one word per handshake, payload held while stalled
  always @(negedge clk) begin
    if (!rst && (!in_valid || tick_taken)) begin
      if (key_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_pins = key_ticks.pop_front();
        key_one_pin <= nxt_pins.one;
        key_two_pin <= nxt_pins.two;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic add_tick(input kdet_pkg::code_t c);
    pins_t p;
    p.one = ~c[0];
    p.two = ~c[1];
    key_ticks.push_back(p);
    n_pushed++;
  endtask

  task automatic add_codes(input string s);
    for (int i = 0; i < s.len(); i++) add_tick(kdet_pkg::code_t'(s[i] - 8'h30));
  endtask

  task automatic settle();
    while (n_results < n_pushed) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic reg_write(input int idx, input int val);
    logic [kdet_pkg::DataW-1:0] data;
    data = $urandom();
    if (idx == kdet_pkg::REG_REPEAT_EN) data[0] = val[0];
    else data[15:0] = val[15:0];
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= kdet_pkg::AddrW'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      kdet_pkg::REG_SCAN_PERIOD:   scan_cfg = data[15:0];
      kdet_pkg::REG_DEBOUNCE_TIME: debounce_cfg = data[15:0];
      kdet_pkg::REG_LONG_TIME:     long_cfg = data[15:0];
      kdet_pkg::REG_REPEAT_TIME:   repeat_cfg = data[15:0];
      kdet_pkg::REG_REPEAT_EN:     repeat_en_cfg = data[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input int scan, input int deb, input int lng, input int rep,
                           input int en, input int words);
    int              hold_max;
    int              gap_max;
    int              target;
    int              kind;
    int              nseq;
    kdet_pkg::code_t c;
    settle();
    reg_write(kdet_pkg::REG_SCAN_PERIOD, scan);
    reg_write(kdet_pkg::REG_DEBOUNCE_TIME, deb);
    reg_write(kdet_pkg::REG_LONG_TIME, lng);
    reg_write(kdet_pkg::REG_REPEAT_TIME, rep);
    reg_write(kdet_pkg::REG_REPEAT_EN, en);
    n_settings++;
    hold_max = deb + lng + 3 * rep + 4 * (scan + 1);
    if (hold_max > 250) hold_max = 250;
    gap_max = 2 * (scan + 1) + 2;
    if (gap_max > 40) gap_max = 40;
    target = n_pushed + words;
    nseq = 0;
    while (n_pushed < target) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        // noise
        repeat ($urandom_range(8, 1)) add_tick(kdet_pkg::code_t'($urandom_range(3)));
      end else begin
        c = kdet_pkg::code_t'($urandom_range(3, 1));
        repeat ($urandom_range(hold_max, 1)) add_tick(c);
        if (kind == 2) c = c ^ kdet_pkg::code_t'($urandom_range(3, 1));
        else c = kdet_pkg::KEY_NONE;
        repeat ($urandom_range(gap_max, 1)) add_tick(c);
      end
      nseq++;
      // hold off until the block has emptied
      if (nseq % 6 == 0) settle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_idle_pct = 18;
    recv_idle_pct = 81;

    // directed: every event, change in debounce, zero periods
    reg_write(kdet_pkg::REG_SCAN_PERIOD, 0);
    reg_write(kdet_pkg::REG_DEBOUNCE_TIME, 1);
    reg_write(kdet_pkg::REG_LONG_TIME, 2);
    reg_write(kdet_pkg::REG_REPEAT_TIME, 0);
    reg_write(kdet_pkg::REG_REPEAT_EN, 1);
    n_settings++;
    add_codes("1111110233300222210");
    settle();
    // out of range writes are dropped; repeats suppressed, zero debounce
    reg_write(REG_UNUSED_LO, 16'hFFFF);
    reg_write(REG_UNUSED_HI, 16'h0001);
    reg_write(kdet_pkg::REG_DEBOUNCE_TIME, 0);
    reg_write(kdet_pkg::REG_REPEAT_EN, 0);
    n_settings++;
    add_codes("3333330");

    run_phase(0, 0, 0, 0, 1, 200);
    for (int i = 0; i < 2; i++)
      run_phase($urandom_range(3), $urandom_range(6), $urandom_range(15),
                $urandom_range(6), $urandom_range(1), 210);

    send_idle_pct = 81;
    recv_idle_pct = 18;
    for (int i = 0; i < 2; i++)
      run_phase($urandom_range(3), $urandom_range(6), $urandom_range(15),
                $urandom_range(6), $urandom_range(1), 210);
    run_phase(10, 20, 100, 30, 1, 300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase($urandom_range(3), $urandom_range(6), $urandom_range(15),
              $urandom_range(6), $urandom_range(1), 210);
    run_phase(1, 65535, 0, 0, 0, 60);
    run_phase(0, 3, 65535, 65535, 1, 80);
    // max scan period last: its countdown never drains within the run
    run_phase(65535, 0, 0, 0, 1, 40);

    settle();
    repeat (8) @(negedge clk);
    if (pending_events.size() != 0) begin
      $display("%0d ticks never produced a result", pending_events.size());
      n_bad++;
    end
    $display("Checked %0d key ticks under %0d register settings, periods from 0 to 65535.",
             n_pushed, n_settings);
    $display("Events predicted: %0d press, %0d short, %0d long, %0d repeat, %0d long release.",
             ev_seen[kdet_pkg::EV_PRESS], ev_seen[kdet_pkg::EV_SHORT],
             ev_seen[kdet_pkg::EV_LONG], ev_seen[kdet_pkg::EV_REPEAT],
             ev_seen[kdet_pkg::EV_LONG_RELEASE]);
    if (n_bad == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
